// File: rtl/smea_pkg.sv
// Shared types and constants of the stream match entry allocator.
// Used by smea_ctrl, smea_datapath and stream_match_entry_allocator_unit.
package smea_pkg;

   localparam int ENTRY_COUNT = 128;
   localparam int STREAM_BITS = 15;
   localparam int IDX_BITS    = $clog2(ENTRY_COUNT);
   localparam int CNT_BITS    = $clog2(ENTRY_COUNT + 1);
   localparam int CFG_BITS    = 8;
   localparam int CTX_BITS    = 8;
   localparam int STATUS_BITS = 3;
   localparam int CMP_BITS    = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int CSR_INDEX_BITS = 4;

   localparam int REQ_FIELD_BITS = 2 * STREAM_BITS + CTX_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STATUS_BITS + IDX_BITS + CTX_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [CFG_BITS-1:0] GROUPS_RESET = CFG_BITS'(128);
   localparam logic [CFG_BITS-1:0] ROOT_RESET   = '0;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUPS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROOT   = CSR_INDEX_BITS'(1);

   localparam logic KIND_ASSIGN  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_NEW     = 3'd0,
      ST_REUSED  = 3'd1,
      ST_OVERLAP = 3'd2,
      ST_FULL    = 3'd3,
      ST_CLEARED = 3'd4,
      ST_HANDED  = 3'd5,
      ST_NONE    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } wr_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic       start;
      logic       scan_en;
      logic       commit;
      status_type status;
      wr_op_type  op;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic done;
      logic hit;
      logic overlap;
      logic free_found;
      logic kind;
      logic hand_back;
      logic out_busy;
   } sts_type;

endpackage

// File: rtl/stream_match_entry_allocator_unit.sv
// Stream match entry allocator, top level: sequencer plus datapath.
// The scan covers entries 0 to min(groups_in_use, 128) - 1 and stops early at the first
// entry that covers or overlaps the request; one word is in work at a time, and its result
// is committed only once the previous result has been taken on rsp_tready;
// the scan reads one entry per cycle through the single read port of the match memory.
// Reset (synchronous, active high): all entries free, groups_in_use = 128,
// root_context = 0; takes effect at once, with no clearing pass.
module stream_match_entry_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request: tuser = kind (0 assign, 1 release).
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, low bit up: stream_id[15], stream_mask[15], context_req[8], hand_back[1], pad.
   input  logic [smea_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tuser,
   // Response.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, low bit up: status[3], entry_index[7], routed_context[8], pad.
   output logic [smea_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // Register writes: index 0 groups_in_use, index 1 root_context.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smea_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [smea_pkg::CFG_BITS-1:0]       csr_data
);

   smea_pkg::cmd_type cmd;
   smea_pkg::sts_type sts;

   // Sequencer: owns the request handshake and decides each outcome.
   smea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: holds the table, scans it and drives the response word.
   smea_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Field views of the response word for the checks below.
   logic [smea_pkg::STATUS_BITS-1:0] chk_status;
   logic [smea_pkg::IDX_BITS-1:0]    chk_idx;
   logic [smea_pkg::CTX_BITS-1:0]    chk_ctx;

   assign chk_status = rsp_tdata[smea_pkg::STATUS_BITS-1:0];
   assign chk_idx    = rsp_tdata[smea_pkg::STATUS_BITS+smea_pkg::IDX_BITS-1:smea_pkg::STATUS_BITS];
   assign chk_ctx    = rsp_tdata[smea_pkg::RSP_FIELD_BITS-1:smea_pkg::STATUS_BITS+smea_pkg::IDX_BITS];

   // Commit only once the scan has settled.
   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.done)
      else $error("commit before scan done");

   // One item at a time: no new word right after an accepted one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice in a row");

   // Outcomes that touch no entry report index and context zero.
   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (chk_status == smea_pkg::ST_OVERLAP || chk_status == smea_pkg::ST_FULL ||
       chk_status == smea_pkg::ST_NONE)) |-> (chk_idx == '0 && chk_ctx == '0))
      else $error("entry fields set on a no-entry outcome");

endmodule

// File: rtl/smea_ctrl.sv
// Sequencer of the stream match entry allocator: accept, scan, commit.
// Depends on smea_pkg.
module smea_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  smea_pkg::sts_type sts,
   output smea_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      // Pick the outcome from the scan flags.
      cmd.status = smea_pkg::ST_NONE;
      cmd.op     = smea_pkg::OP_NONE;
      if (sts.kind == smea_pkg::KIND_ASSIGN) begin
         if (sts.hit) begin
            cmd.status = smea_pkg::ST_REUSED;
            cmd.op     = smea_pkg::OP_SET;
         end else if (sts.overlap) begin
            cmd.status = smea_pkg::ST_OVERLAP;
         end else if (sts.free_found) begin
            cmd.status = smea_pkg::ST_NEW;
            cmd.op     = smea_pkg::OP_SET;
         end else begin
            cmd.status = smea_pkg::ST_FULL;
         end
      end else if (sts.hit) begin
         if (sts.hand_back) begin
            cmd.status = smea_pkg::ST_HANDED;
         end else begin
            cmd.status = smea_pkg::ST_CLEARED;
            cmd.op     = smea_pkg::OP_CLEAR;
         end
      end

      state_in    = state_ff;
      cmd.start   = 1'b0;
      cmd.scan_en = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/smea_datapath.sv
// Datapath of the stream match entry allocator: config registers, match memory,
// valid bits, one-entry-per-cycle compare and the result register. Depends on smea_pkg.
module smea_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smea_pkg::cmd_type                     cmd,
   output smea_pkg::sts_type                     sts,
   input  logic                                  req_tuser,
   input  logic [smea_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [smea_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [smea_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [smea_pkg::CFG_BITS-1:0]         csr_data
);

   localparam int SB = smea_pkg::STREAM_BITS;
   localparam int IB = smea_pkg::IDX_BITS;
   localparam int CB = smea_pkg::CTX_BITS;

   // Configuration.
   logic [smea_pkg::CFG_BITS-1:0] groups_ff, groups_in;
   logic [smea_pkg::CFG_BITS-1:0] root_ff, root_in;

   // Item under work.
   logic          kind_ff, kind_in;
   logic [SB-1:0] id_ff, id_in;
   logic [SB-1:0] mask_ff, mask_in;
   logic [CB-1:0] ctx_ff, ctx_in;
   logic          back_ff, back_in;

   // Scan pipeline.
   logic [smea_pkg::CNT_BITS-1:0] issue_ff, issue_in;
   logic          live_ff, live_in;
   logic [IB-1:0] live_idx_ff, live_idx_in;
   logic          live_vld_ff, live_vld_in;
   logic          done_ff, done_in;
   logic          hit_ff, hit_in;
   logic          ovl_ff, ovl_in;
   logic          free_ff, free_in;
   logic [IB-1:0] hit_idx_ff, hit_idx_in;
   logic [IB-1:0] free_idx_ff, free_idx_in;

   logic [smea_pkg::ENTRY_COUNT-1:0] valid_ff, valid_in;

   // Match memory: {mask, id} per entry.
   logic [2*SB-1:0] mem [smea_pkg::ENTRY_COUNT];
   logic [2*SB-1:0] rd_data_ff;
   logic [IB-1:0]   rd_addr;
   logic            wr_en;
   logic [IB-1:0]   slot;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [smea_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [IB-1:0]            rsp_idx_ff, rsp_idx_in;
   logic [CB-1:0]            rsp_ctx_ff, rsp_ctx_in;

   logic [smea_pkg::CMP_BITS-1:0] lim;
   logic          issue_ok;
   logic [SB-1:0] ent_id, ent_mask, diff;
   logic          covered, overlap;

   assign csr_ready = 1'b1;

   always_comb begin
      groups_in = groups_ff;
      root_in   = root_ff;
      if (csr_valid) begin
         unique case (csr_index)
            smea_pkg::CSR_GROUPS: groups_in = csr_data;
            smea_pkg::CSR_ROOT:   root_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Clamp the scan limit to the table size.
   always_comb begin
      if (smea_pkg::CMP_BITS'(groups_ff) > smea_pkg::CMP_BITS'(smea_pkg::ENTRY_COUNT)) begin
         lim = smea_pkg::CMP_BITS'(smea_pkg::ENTRY_COUNT);
      end else begin
         lim = smea_pkg::CMP_BITS'(groups_ff);
      end
   end

   assign issue_ok = smea_pkg::CMP_BITS'(issue_ff) < lim;
   assign rd_addr  = issue_ff[IB-1:0];

   assign ent_id   = rd_data_ff[SB-1:0];
   assign ent_mask = rd_data_ff[2*SB-1:SB];
   assign diff     = id_ff ^ ent_id;
   assign covered  = ((mask_ff & ent_mask) == mask_ff) && ((diff & ~ent_mask) == '0);
   assign overlap  = (diff & ~(ent_mask | mask_ff)) == '0;

   assign slot  = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wr_en = cmd.commit && (cmd.op == smea_pkg::OP_SET);

   // Item load and scan.
   always_comb begin
      kind_in     = kind_ff;
      id_in       = id_ff;
      mask_in     = mask_ff;
      ctx_in      = ctx_ff;
      back_in     = back_ff;
      issue_in    = issue_ff;
      live_in     = live_ff;
      live_idx_in = live_idx_ff;
      live_vld_in = live_vld_ff;
      done_in     = done_ff;
      hit_in      = hit_ff;
      ovl_in      = ovl_ff;
      free_in     = free_ff;
      hit_idx_in  = hit_idx_ff;
      free_idx_in = free_idx_ff;
      if (cmd.start) begin
         kind_in  = req_tuser;
         id_in    = req_tdata[SB-1:0];
         mask_in  = req_tdata[2*SB-1:SB];
         ctx_in   = req_tdata[2*SB+CB-1:2*SB];
         back_in  = req_tdata[2*SB+CB];
         issue_in = '0;
         live_in  = 1'b0;
         done_in  = 1'b0;
         hit_in   = 1'b0;
         ovl_in   = 1'b0;
         free_in  = 1'b0;
      end else if (cmd.scan_en && !done_ff) begin
         // Issue the next read while the previous entry is compared.
         live_in = issue_ok;
         if (issue_ok) begin
            live_idx_in = rd_addr;
            live_vld_in = valid_ff[rd_addr];
            issue_in    = issue_ff + 1'b1;
         end
         if (live_ff) begin
            if (live_vld_ff) begin
               if (covered) begin
                  hit_in     = 1'b1;
                  hit_idx_in = live_idx_ff;
                  done_in    = 1'b1;
               end else if (overlap) begin
                  ovl_in  = 1'b1;
                  done_in = 1'b1;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = live_idx_ff;
            end
         end else if (!issue_ok) begin
            done_in = 1'b1;
         end
      end
   end

   // Valid bits and result register.
   always_comb begin
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ctx_in    = rsp_ctx_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         case (cmd.op)
            smea_pkg::OP_SET:   valid_in[slot] = 1'b1;
            smea_pkg::OP_CLEAR: valid_in[slot] = 1'b0;
            default: ;
         endcase
         case (cmd.status) inside
            smea_pkg::ST_NEW, smea_pkg::ST_REUSED: begin
               rsp_idx_in = slot;
               rsp_ctx_in = ctx_ff;
            end
            smea_pkg::ST_HANDED: begin
               rsp_idx_in = slot;
               rsp_ctx_in = root_ff;
            end
            smea_pkg::ST_CLEARED: begin
               rsp_idx_in = slot;
               rsp_ctx_in = '0;
            end
            default: begin
               rsp_idx_in = '0;
               rsp_ctx_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= {mask_ff, id_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff    <= smea_pkg::GROUPS_RESET;
         root_ff      <= smea_pkg::ROOT_RESET;
         valid_ff     <= '0;
         live_ff      <= 1'b0;
         done_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         ovl_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         groups_ff    <= groups_in;
         root_ff      <= root_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         done_ff      <= done_in;
         hit_ff       <= hit_in;
         ovl_ff       <= ovl_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      mask_ff       <= mask_in;
      ctx_ff        <= ctx_in;
      back_ff       <= back_in;
      issue_ff      <= issue_in;
      live_idx_ff   <= live_idx_in;
      live_vld_ff   <= live_vld_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ctx_ff    <= rsp_ctx_in;
   end

   assign sts.done       = done_ff;
   assign sts.hit        = hit_ff;
   assign sts.overlap    = ovl_ff;
   assign sts.free_found = free_ff;
   assign sts.kind       = kind_ff;
   assign sts.hand_back  = back_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = smea_pkg::RSP_DATA_BITS'({rsp_ctx_ff, rsp_idx_ff, rsp_status_ff});

endmodule
